@@ hw/rtl/interval_split_at_times_defines.svh @@
// Assertion macros used by the interval splitter controller.
`ifndef INTERVAL_SPLIT_AT_TIMES_DEFINES_SVH
`define INTERVAL_SPLIT_AT_TIMES_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define IST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("interval splitter check failed");

// Next-cycle implication, checked outside reset.
`define IST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("interval splitter check failed");

`endif

@@ hw/rtl/ist_pkg.sv @@
package ist_pkg;

  localparam int TIME_W        = 32;
  localparam int CTR_W         = 16;
  localparam int MAX_TIMES_DEF = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_SPLIT  = 2'd2
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_EMIT,
    PH_DONE
  } phase_t;

  // Command from the controller to every cell of the chain.
  typedef struct packed {
    logic                     shift;
    logic                     load;
    logic signed [TIME_W-1:0] data;
  } chain_cmd_t;

endpackage

@@ hw/rtl/ist_cell.sv @@
module ist_cell
  import ist_pkg::*;
(
  input  logic                     clk,
  input  chain_cmd_t               cmd,
  input  logic                     sel,
  input  logic signed [TIME_W-1:0] shift_in,
  output logic signed [TIME_W-1:0] value
);

  // Rotation has priority; loads only happen while the chain is at rest.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      value <= shift_in;
    end else if (cmd.load && sel) begin
      value <= cmd.data;
    end
  end

endmodule

@@ hw/rtl/ist_ctrl.sv @@
`include "interval_split_at_times_defines.svh"

module ist_ctrl
  import ist_pkg::*;
#(
  parameter int MAX_TIMES = MAX_TIMES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [TIME_W-1:0] cut_time,
  input  logic signed [TIME_W-1:0] interval_start,
  input  logic signed [TIME_W-1:0] interval_stop,
  input  logic signed [TIME_W-1:0] head,
  output chain_cmd_t               cmd,
  output logic [MAX_TIMES-1:0]     sel,
  output logic                     result_strobe,
  output logic signed [TIME_W-1:0] piece_start,
  output logic signed [TIME_W-1:0] piece_stop,
  output logic [CTR_W-1:0]         source_row,
  output logic [CTR_W-1:0]         piece_total,
  output logic                     last_piece
);

  localparam int IDX_W = $clog2(MAX_TIMES + 1);
  localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_TIMES);

  state_t                   state, state_next;
  phase_t                   phase, phase_next;
  logic [IDX_W-1:0]         count, count_next;
  logic [IDX_W-1:0]         step, step_next;
  logic [CTR_W-1:0]         row, row_next;
  logic [CTR_W-1:0]         pieces, pieces_next;
  logic signed [TIME_W-1:0] lo, lo_next;
  logic signed [TIME_W-1:0] hi, hi_next;
  logic signed [TIME_W-1:0] cur, cur_next;
  logic                     strobe_next;
  logic signed [TIME_W-1:0] pstart_next, pstop_next;
  logic                     last_next;
  logic                     accept;
  logic                     in_table;
  logic                     skip_now;
  logic                     between;

  assign busy   = (state == ST_SCAN);
  assign accept = start && !busy;

  always_comb begin
    for (int i = 0; i < MAX_TIMES; i++) begin
      sel[i] = (count == IDX_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PH_DONE;
      count         <= '0;
      step          <= '0;
      row           <= '0;
      pieces        <= '0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      phase         <= phase_next;
      count         <= count_next;
      step          <= step_next;
      row           <= row_next;
      pieces        <= pieces_next;
      result_strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    lo          <= lo_next;
    hi          <= hi_next;
    cur         <= cur_next;
    piece_start <= pstart_next;
    piece_stop  <= pstop_next;
    source_row  <= row;
    piece_total <= pieces_next;
    last_piece  <= last_next;
  end

  always_comb begin
    state_next  = state;
    phase_next  = phase;
    count_next  = count;
    step_next   = step;
    row_next    = row;
    pieces_next = pieces;
    lo_next     = lo;
    hi_next     = hi;
    cur_next    = cur;
    strobe_next = 1'b0;
    pstart_next = cur;
    pstop_next  = hi;
    last_next   = 1'b0;
    cmd.shift   = 1'b0;
    cmd.load    = 1'b0;
    cmd.data    = cut_time;

    in_table = (step < count);
    between  = in_table && (head > lo) && (head < hi);
    skip_now = (phase == PH_SKIP) && in_table && !(head > lo);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_CLEAR: begin
              count_next  = '0;
              row_next    = '0;
              pieces_next = '0;
            end
            OP_APPEND: begin
              if (count < LAST_STEP) begin
                cmd.load   = 1'b1;
                count_next = count + 1'b1;
              end
            end
            OP_SPLIT: begin
              row_next   = (row == '1) ? row : row + 1'b1;
              lo_next    = interval_start;
              hi_next    = interval_stop;
              cur_next   = interval_start;
              step_next  = '0;
              phase_next = PH_SKIP;
              state_next = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Rotate the chain once per step but the last; a full turn restores table order.
        cmd.shift = (step != LAST_STEP);
        step_next = step + 1'b1;
        if (phase != PH_DONE && !skip_now) begin
          strobe_next = 1'b1;
          pieces_next = (pieces == '1) ? pieces : pieces + 1'b1;
          if (between) begin
            pstop_next = head;
            cur_next   = head;
            phase_next = PH_EMIT;
          end else begin
            last_next  = 1'b1;
            phase_next = PH_DONE;
          end
        end
        if (step == LAST_STEP) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `IST_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= LAST_STEP)
  `IST_ASSERT_NOW(a_total_nonzero, clk, rst, result_strobe, piece_total != '0)
  `IST_ASSERT_NEXT(a_last_ends, clk, rst, result_strobe && last_piece, !result_strobe)
  `IST_ASSERT_NEXT(a_split_busy, clk, rst, accept && opcode == OP_SPLIT, busy)
  `IST_ASSERT_NEXT(a_scan_final, clk, rst, busy && step == LAST_STEP && phase != PH_DONE,
                   result_strobe && last_piece)

endmodule

@@ hw/rtl/interval_split_at_times.sv @@
// Channel   Handshake          Fields
// request   start / busy       opcode, cut_time, interval_start, interval_stop
// result    result_strobe      piece_start, piece_stop, source_row, piece_total,
//                              last_piece
//
// Clear, append and unused codes complete without raising busy.
// A split request holds busy while the cell chain turns
// once, one cell per cycle, and emits at most one piece per cycle.
// Pieces appear in the cycle after the chain step that produced them.
// rst is synchronous and empties the table and both counters.
// Results carry no back-pressure: each strobe lasts exactly one cycle.
module interval_split_at_times
  import ist_pkg::*;
#(
  parameter int MAX_TIMES = MAX_TIMES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               opcode,
  input  logic signed [TIME_W-1:0] cut_time,
  input  logic signed [TIME_W-1:0] interval_start,
  input  logic signed [TIME_W-1:0] interval_stop,
  output logic                     result_strobe,
  output logic signed [TIME_W-1:0] piece_start,
  output logic signed [TIME_W-1:0] piece_stop,
  output logic [CTR_W-1:0]         source_row,
  output logic [CTR_W-1:0]         piece_total,
  output logic                     last_piece
);

  chain_cmd_t               cmd;
  logic [MAX_TIMES-1:0]     sel;
  logic signed [TIME_W-1:0] cell_q [MAX_TIMES];

  for (genvar i = 0; i < MAX_TIMES; i++) begin : g_chain
    localparam int NXT = (i == MAX_TIMES - 1) ? 0 : i + 1;
    ist_cell u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .sel      (sel[i]),
      .shift_in (cell_q[NXT]),
      .value    (cell_q[i])
    );
  end

  ist_ctrl #(
    .MAX_TIMES (MAX_TIMES)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .cut_time       (cut_time),
    .interval_start (interval_start),
    .interval_stop  (interval_stop),
    .head           (cell_q[0]),
    .cmd            (cmd),
    .sel            (sel),
    .result_strobe  (result_strobe),
    .piece_start    (piece_start),
    .piece_stop     (piece_stop),
    .source_row     (source_row),
    .piece_total    (piece_total),
    .last_piece     (last_piece)
  );

endmodule
